[rtl/lbp_pkg.sv]
package lbp_pkg;

   // Field widths of the request and response channels
   localparam int VAL_W  = 64;
   localparam int CNT_W  = 7;
   localparam int IDX_W  = 12;
   localparam int FILL_W = 13;

   // Store organization
   localparam int WORD_BITS      = 64;
   localparam int OFS_W          = 6;
   localparam int STORE_BITS_DEF = 4096;

   typedef logic [WORD_BITS-1:0] word_type;

   // Request opcodes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Response status codes
   localparam logic STAT_OK       = 1'b0;
   localparam logic STAT_OVERFLOW = 1'b1;

   // Mask of the low n bits, all ones for n of a full word or more
   function automatic word_type low_mask(input logic [CNT_W-1:0] n);
      word_type m;
      if (n >= CNT_W'(WORD_BITS)) begin
         m = '1;
      end else begin
         m = (word_type'(1) << n) - word_type'(1);
      end
      return m;
   endfunction

endpackage

[rtl/lbp_if.sv]
interface lbp_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [lbp_pkg::VAL_W-1:0]  field_value;
   logic [lbp_pkg::CNT_W-1:0]  bit_count;
   logic [lbp_pkg::IDX_W-1:0]  bit_index;

   modport source (output valid, output opcode, output field_value, output bit_count,
                   output bit_index, input ready);
   modport sink (input valid, input opcode, input field_value, input bit_count,
                 input bit_index, output ready);
endinterface

interface lbp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       bit_value;
   logic [lbp_pkg::FILL_W-1:0] fill_length;
   logic                       status;

   modport source (output valid, output bit_value, output fill_length, output status,
                   input ready);
   modport sink (input valid, input bit_value, input fill_length, input status,
                 output ready);
endinterface

[rtl/lsb_first_bit_packer_top.sv]
// LSB-first bit packer.
// Request channel (req_bus): opcode selects an append or a single-bit read.
//   An append masks field_value to bit_count bits (counts above 64 act as 64)
//   and places them at the current fill length, least significant bit first.
//   A read returns the stored bit at bit_index.
// Response channel (rsp_bus): one response per request, carrying the bit read
//   (zero for appends), the fill length after the request and a status bit
//   that flags an append rejected because it would overflow the store.
// Response path: a taken request has its word read, the look state merges the
//   field and writes back, a word-crossing append passes the spill state, and the
//   result is then registered in the output register. Requests are taken only in
//   the idle state, so a new request waits until the last result has left the
//   sequencer. The store sits in a single-write-port RAM: an append writes back
//   its merged word, and a crossing append writes a second word in the spill state.
// Reset clears the fill length and the response valid flag. The RAM is not
//   swept: bits at or beyond the fill length are masked on reads and on merge,
//   so they always read as zero.
// A stalled receiver holds the response in the output register; one more
//   request is taken meanwhile and parks its result until the register frees.
module lsb_first_bit_packer_top #(
   parameter int STORE_BITS = lbp_pkg::STORE_BITS_DEF
) (
   input logic             clock,
   input logic             reset,
   lbp_req_if.sink         req_bus,
   lbp_rsp_if.source       rsp_bus
);

   localparam int WORD_BITS   = lbp_pkg::WORD_BITS;
   localparam int OFS_W       = lbp_pkg::OFS_W;
   localparam int CNT_W       = lbp_pkg::CNT_W;
   localparam int FILL_W      = lbp_pkg::FILL_W;
   localparam int IDX_W       = lbp_pkg::IDX_W;
   localparam int STORE_WORDS = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW          = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;
   localparam int FW          = $clog2(STORE_BITS + 1);
   // Wide enough for fill + count and for a zero-extended bit index
   localparam int XW          = (FW > IDX_W ? FW : IDX_W) + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_SPILL = 2'd2;
   localparam logic [1:0] S_HOLD  = 2'd3;

   // Sequencer and latched request
   logic [1:0]              state_ff, state_in;
   logic                    op_ff, op_in;
   lbp_pkg::word_type       value_ff, value_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        index_ff, index_in;
   logic [FW-1:0]           fill_ff, fill_in;
   lbp_pkg::word_type       spill_ff, spill_in;
   logic [AW-1:0]           spill_addr_ff, spill_addr_in;

   // Parked result and output register
   logic                    res_bit_ff, res_bit_in;
   logic [FILL_W-1:0]       res_fill_ff, res_fill_in;
   logic                    res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_bit_ff, rsp_bit_in;
   logic [FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;
   logic                    rsp_status_ff, rsp_status_in;

   // RAM port
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   lbp_pkg::word_type       wr_data;
   lbp_pkg::word_type       rd_data;

   // Datapath of the look cycle
   logic [XW-1:0]           fill_x;
   logic [XW-1:0]           idx_x;
   logic [XW-1:0]           req_idx_x;
   logic [XW-1:0]           sum_x;
   logic [OFS_W-1:0]        off;
   logic [2*WORD_BITS-1:0]  shifted;
   lbp_pkg::word_type       word0;
   logic                    over;
   logic                    do_app;
   logic                    spill;
   logic [FW-1:0]           new_fill;
   logic                    look_bit;
   logic                    look_status;
   logic [CNT_W-1:0]        req_cnt;
   logic                    req_fire;
   logic                    out_free;

   lbp_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Saturate the count to one word
   assign req_cnt   = (req_bus.bit_count > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS)
                                                              : req_bus.bit_count;
   assign req_idx_x = XW'(req_bus.bit_index);

   // Merge the new field into the word read back
   assign fill_x   = XW'(fill_ff);
   assign idx_x    = XW'(index_ff);
   assign off      = fill_ff[OFS_W-1:0];
   assign sum_x    = fill_x + XW'(cnt_ff);
   assign over     = sum_x > XW'(STORE_BITS);
   assign do_app   = (op_ff == lbp_pkg::OP_APPEND) && !over && (cnt_ff != '0);
   assign shifted  = {{WORD_BITS{1'b0}}, value_ff} << off;
   assign word0    = (rd_data & lbp_pkg::low_mask(CNT_W'(off))) | shifted[WORD_BITS-1:0];
   assign spill    = do_app && ((8'(off) + 8'(cnt_ff)) > 8'(WORD_BITS));
   assign new_fill = do_app ? FW'(sum_x) : fill_ff;

   // Bits at or past the fill length may hold stale data: force zero
   assign look_bit    = (op_ff == lbp_pkg::OP_READ) && (idx_x < fill_x)
                        && rd_data[index_ff[OFS_W-1:0]];
   assign look_status = ((op_ff == lbp_pkg::OP_APPEND) && over) ? lbp_pkg::STAT_OVERFLOW
                                                                 : lbp_pkg::STAT_OK;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      cnt_in        = cnt_ff;
      index_in      = index_ff;
      fill_in       = fill_ff;
      spill_in      = spill_ff;
      spill_addr_in = spill_addr_ff;
      res_bit_in    = res_bit_ff;
      res_fill_in   = res_fill_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_bit_in    = rsp_bit_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = fill_x[AW+OFS_W-1:OFS_W];
      wr_en         = 1'b0;
      wr_addr       = fill_x[AW+OFS_W-1:OFS_W];
      wr_data       = word0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_bus.opcode;
               value_in = req_bus.field_value & lbp_pkg::low_mask(req_cnt);
               cnt_in   = req_cnt;
               index_in = req_bus.bit_index;
               rd_en    = 1'b1;
               if (req_bus.opcode == lbp_pkg::OP_READ) begin
                  rd_addr = req_idx_x[AW+OFS_W-1:OFS_W];
               end
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // For an accepted append, write back the merged word and advance the fill length
            wr_en         = do_app;
            fill_in       = new_fill;
            spill_in      = shifted[2*WORD_BITS-1:WORD_BITS];
            spill_addr_in = fill_x[AW+OFS_W-1:OFS_W] + AW'(1);
            res_bit_in    = look_bit;
            res_fill_in   = FILL_W'(new_fill);
            res_status_in = look_status;
            if (spill) begin
               state_in = S_SPILL;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bit_in    = look_bit;
               rsp_fill_in   = FILL_W'(new_fill);
               rsp_status_in = look_status;
               state_in      = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_SPILL: begin
            // The upper part lands in a fresh word: no read needed
            wr_en   = 1'b1;
            wr_addr = spill_addr_ff;
            wr_data = spill_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bit_in    = res_bit_ff;
               rsp_fill_in   = res_fill_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // Hold the result until the output register frees
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_bit_in    = res_bit_ff;
               rsp_fill_in   = res_fill_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      cnt_ff        <= cnt_in;
      index_ff      <= index_in;
      spill_ff      <= spill_in;
      spill_addr_ff <= spill_addr_in;
      res_bit_ff    <= res_bit_in;
      res_fill_ff   <= res_fill_in;
      res_status_ff <= res_status_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.bit_value   = rsp_bit_ff;
   assign rsp_bus.fill_length = rsp_fill_ff;
   assign rsp_bus.status      = rsp_status_ff;

endmodule

[rtl/lbp_ram.sv]
module lbp_ram #(
   parameter int WIDTH = lbp_pkg::WORD_BITS,
   parameter int DEPTH = lbp_pkg::STORE_BITS_DEF / lbp_pkg::WORD_BITS
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lbp_checker.sv]
module lbp_checker #(
   parameter int STORE_BITS = lbp_pkg::STORE_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_bit_value,
   input logic [lbp_pkg::FILL_W-1:0] rsp_fill_length,
   input logic                       rsp_status
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bit_value)
         && $stable(rsp_fill_length) && $stable(rsp_status))
      else $error("stalled response changed");

   // A taken request moves the block out of the idle state, so the next request must wait
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in consecutive cycles");

   // A rejected append never reports a stored bit
   a_reject_no_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lbp_pkg::STAT_OVERFLOW) |-> !rsp_bit_value)
      else $error("rejected append carries a bit");

   // Fill length stays within the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (STORE_BITS > 8191) || (rsp_fill_length <= STORE_BITS))
      else $error("fill length past store size");

endmodule

bind lsb_first_bit_packer_top lbp_checker #(
   .STORE_BITS (STORE_BITS)
) u_lbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_bit_value   (rsp_bus.bit_value),
   .rsp_fill_length (rsp_bus.fill_length),
   .rsp_status      (rsp_bus.status)
);

[verif/testbench.sv]
module testbench;

   localparam int STORE_SIZE   = lbp_pkg::STORE_BITS_DEF;
   localparam int WORD_BITS    = lbp_pkg::WORD_BITS;
   localparam int CNT_W        = lbp_pkg::CNT_W;
   localparam int IDX_W        = lbp_pkg::IDX_W;
   localparam int FILL_W       = lbp_pkg::FILL_W;
   localparam int STORE_WORDS  = STORE_SIZE / WORD_BITS;
   localparam int RANDOM_ITEMS = 1730;
   localparam int QUIET_TAIL   = 250;
   localparam int STALL_LIMIT  = 3000;

   localparam logic OP_APPEND     = lbp_pkg::OP_APPEND;
   localparam logic OP_READ       = lbp_pkg::OP_READ;
   localparam logic STAT_OK       = lbp_pkg::STAT_OK;
   localparam logic STAT_OVERFLOW = lbp_pkg::STAT_OVERFLOW;

   typedef lbp_pkg::word_type word_type;

   // One response as the block should return it
   typedef struct packed {
      logic              bit_value;
      logic [FILL_W-1:0] fill_length;
      logic              status;
   } packer_rsp_type;

   // Shadow copy of the bit store plus the responses still owed by the block
   class packer_shadow_type;
      word_type       shadow_words[STORE_WORDS];
      int             shadow_fill;
      packer_rsp_type awaited[$];
      int             error_count;
      int             rsp_seen;

      function new();
         foreach (shadow_words[w]) shadow_words[w] = '0;
         shadow_fill = 0;
         error_count = 0;
         rsp_seen    = 0;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // Apply one accepted request to the shadow store and queue its response
      function void note_request(input logic op, input word_type val,
                                 input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx);
         packer_rsp_type rsp;
         int             eff;
         int             word_sel;
         int             bit_ofs;
         word_type       kept;
         rsp = '0;
         rsp.status = STAT_OK;
         if (op == OP_APPEND) begin
            eff = (cnt > CNT_W'(WORD_BITS)) ? WORD_BITS : int'(cnt);
            if (shadow_fill + eff > STORE_SIZE) begin
               rsp.status = STAT_OVERFLOW;
            end else if (eff > 0) begin
               word_sel = shadow_fill / WORD_BITS;
               bit_ofs  = shadow_fill % WORD_BITS;
               kept = '1;
               if (eff < WORD_BITS) kept = ~(kept << eff);
               kept &= val;
               shadow_words[word_sel] |= kept << bit_ofs;
               if (bit_ofs + eff > WORD_BITS && word_sel + 1 < STORE_WORDS) begin
                  shadow_words[word_sel + 1] |= kept >> (WORD_BITS - bit_ofs);
               end
               shadow_fill += eff;
            end
         end else begin
            rsp.bit_value = shadow_words[idx / WORD_BITS][idx % WORD_BITS];
         end
         rsp.fill_length = FILL_W'(shadow_fill);
         awaited.push_back(rsp);
      endfunction

      task report_mismatch(input string what);
         $display("MISMATCH response %0d: %s", rsp_seen, what);
         error_count++;
      endtask

      // Compare one accepted response with the oldest one owed
      task check_response(input logic bv, input logic [FILL_W-1:0] fl, input logic st);
         packer_rsp_type want;
         rsp_seen++;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("no request pending (bit %0b fill %0d status %0b)",
                                      bv, fl, st));
            return;
         end
         want = awaited.pop_front();
         if (bv !== want.bit_value)
            report_mismatch($sformatf("bit_value %0b, want %0b", bv, want.bit_value));
         if (fl !== want.fill_length)
            report_mismatch($sformatf("fill_length %0d, want %0d", fl, want.fill_length));
         if (st !== want.status)
            report_mismatch($sformatf("status %0b, want %0b", st, want.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   idle_mode = 0;   // 0 none, 1 light, 2 heavy; shared by both sides
   int   stall_cycles = 0;

   packer_shadow_type sb = new();

   lbp_req_if req_bus();
   lbp_rsp_if rsp_bus();

   lsb_first_bit_packer_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // Drive one request and hold it until the block takes it; leave valid high
   task automatic send_request(input logic op, input word_type val,
                               input logic [CNT_W-1:0] cnt, input logic [IDX_W-1:0] idx);
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.field_value <= val;
      req_bus.bit_count   <= cnt;
      req_bus.bit_index   <= idx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(op, val, cnt, idx);
   endtask

   // Drop valid for a burst of cycles
   task automatic hold_off(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Receiver side: random stall bursts, none while idle_mode is 0
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         if (idle_mode == 0 || (idle_mode == 1 && $urandom_range(0, 5) != 0) ||
             (idle_mode == 2 && $urandom_range(0, 1) != 0)) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // Check every response taken at a clock edge
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         sb.check_response(rsp_bus.bit_value, rsp_bus.fill_length, rsp_bus.status);
      end
   end

   // Watchdog: count cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("lsb_first_bit_packer_top test failed");
         $finish;
      end
   end

   initial begin
      int       pick;
      int       room;
      int       upper;
      int       idx_int;
      logic     op;
      word_type val;
      int       cnt;

      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_APPEND;
      req_bus.field_value <= '0;
      req_bus.bit_count   <= '0;
      req_bus.bit_index   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty read, single bit, full-word crossing append,
      // zero count, oversized counts, masking of high value bits, word edges
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(0));
      send_request(OP_APPEND, '1,                        CNT_W'(1),   IDX_W'(0));
      send_request(OP_APPEND, '1,                        CNT_W'(64),  '1);
      send_request(OP_APPEND, '1,                        CNT_W'(0),   IDX_W'(0));
      send_request(OP_APPEND, {$urandom, $urandom},      CNT_W'(127), IDX_W'(0));
      send_request(OP_APPEND, '1,                        CNT_W'(65),  IDX_W'(0));
      send_request(OP_APPEND, '0,                        CNT_W'(63),  '1);
      send_request(OP_APPEND, 64'hA5A5_A5A5_A5A5_A5A5,   CNT_W'(3),   IDX_W'(0));
      send_request(OP_APPEND, 64'h8000_0000_0000_0001,   CNT_W'(64),  IDX_W'(0));
      send_request(OP_APPEND, 64'hFFFF_FFFF_FFFF_FF80,   CNT_W'(7),   IDX_W'(0));
      send_request(OP_READ,   '1,                        '1,          IDX_W'(0));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(1));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(63));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(64));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(65));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(128));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(258));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(sb.shadow_fill - 1));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(sb.shadow_fill));
      send_request(OP_READ,   '0,                        CNT_W'(0),   IDX_W'(4032));
      send_request(OP_READ,   '0,                        CNT_W'(0),   '1);

      // Pause the sender until the block has answered everything
      drain_responses();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // Change the idling pattern every 150 requests; go quiet at the end
         if (i % 150 == 0) idle_mode = $urandom_range(0, 2);
         if (i >= RANDOM_ITEMS - QUIET_TAIL) idle_mode = 0;

         if (i == RANDOM_ITEMS / 2) drain_responses();
         else if ((idle_mode == 1 && $urandom_range(0, 9) == 0) ||
                  (idle_mode == 2 && $urandom_range(0, 2) == 0)) begin
            hold_off($urandom_range(1, 18));
         end

         op  = ($urandom_range(0, 99) < 45) ? OP_READ : OP_APPEND;
         val = {$urandom, $urandom};
         cnt = $urandom_range(0, 127);
         idx_int = $urandom_range(0, STORE_SIZE - 1);

         if (op == OP_APPEND) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) val = '1;
            else if (pick == 1) val = '0;

            // Spread the fill over the run: size counts from the room left
            room  = STORE_SIZE - sb.shadow_fill;
            upper = (4 * room) / (RANDOM_ITEMS - i + 1);
            if (upper < 1) upper = 1;
            if (upper > WORD_BITS) upper = WORD_BITS;
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               cnt = 0;
            end else if (pick < 10 && (upper >= 16 || room < WORD_BITS)) begin
               cnt = ($urandom_range(0, 1) != 0) ? WORD_BITS : $urandom_range(65, 127);
            end else if (pick < 16 && room <= WORD_BITS) begin
               cnt = room;   // fill exactly to the top of the store
            end else if (pick < 20 && room < WORD_BITS) begin
               cnt = $urandom_range(room, WORD_BITS);   // mostly rejected
            end else begin
               cnt = $urandom_range(1, upper);
            end
         end else begin
            // Aim reads around written data, the fill edge and word edges
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               idx_int = $urandom_range(0, sb.shadow_fill + 8);
            end else if (pick < 6) begin
               idx_int = sb.shadow_fill + $urandom_range(0, 4) - 2;
            end else if (pick < 8) begin
               idx_int = $urandom_range(0, STORE_WORDS - 1) * WORD_BITS +
                         (($urandom_range(0, 1) != 0) ? WORD_BITS - 1 : 0);
            end
            if (idx_int < 0) idx_int = 0;
            if (idx_int > STORE_SIZE - 1) idx_int = STORE_SIZE - 1;
         end

         send_request(op, val, CNT_W'(cnt), IDX_W'(idx_int));
      end

      // Wait out the last responses, then keep watching for stray ones
      drain_responses();
      repeat (8) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("lsb_first_bit_packer_top test passed");
      end else begin
         $display("lsb_first_bit_packer_top test failed");
      end
      $finish;
   end

endmodule
